### src/sbdc_pkg.sv
// Shared types, constants and functions of the base64 decoder with CRC32c check.
package sbdc_pkg;

    localparam int MAX_CHUNK_BYTES = 4096;
    localparam logic [31:0] CRC_POLY = 32'h82f6_3b78;
    localparam logic [31:0] CRC_INIT = 32'hffff_ffff;
    localparam logic [13:0] CAP_RESET = 14'd4096;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MALFORMED = 3'd1,
        ST_NOSPACE   = 3'd2,
        ST_TOOBIG    = 3'd3,
        ST_CRC       = 3'd4
    } status_t;

    // classified input item, as held in the queue
    typedef struct packed {
        logic        is_end;
        logic [5:0]  sextet;
        logic        bad;
        logic        is_pad;
        logic [31:0] crc_check;
    } item_t;

    function automatic logic [31:0] crc_fold(logic [31:0] crc_in, logic [7:0] data);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            crc = (crc >> 1) ^ (crc[0] ? CRC_POLY : 32'd0);
        end
        return crc;
    endfunction

    // bit 6 set: not an alphabet symbol
    function automatic logic [6:0] sextet_of(logic [7:0] ch);
        logic [7:0] v;
        v = 8'd64;
        if (ch >= 8'h41 && ch <= 8'h5a)
        begin
            v = ch - 8'h41;
        end
        else if (ch >= 8'h61 && ch <= 8'h7a)
        begin
            v = ch - 8'h61 + 8'd26;
        end
        else if (ch >= 8'h30 && ch <= 8'h39)
        begin
            v = ch - 8'h30 + 8'd52;
        end
        else if (ch == 8'h2b)
        begin
            v = 8'd62;
        end
        else if (ch == 8'h2f)
        begin
            v = 8'd63;
        end
        return v[6:0];
    endfunction

endpackage

### src/sbdc_front.sv
// Input side: symbol classification and a two-entry item queue.
module sbdc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  logic [7:0]          symbol,
    input  logic [31:0]         crc_check,
    output logic                deq_valid,
    input  logic                deq_ready,
    output sbdc_pkg::item_t     deq_item
);

    sbdc_pkg::item_t q_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      cnt_reg;
    logic [1:0]      cnt_next;
    sbdc_pkg::item_t cls;
    logic [6:0]      sx;
    logic            push;
    logic            pop;

    always_comb
    begin
        sx            = sbdc_pkg::sextet_of(symbol);
        cls.is_end    = kind;
        cls.bad       = sx[6];
        cls.sextet    = sx[6] ? 6'd0 : sx[5:0];
        cls.is_pad    = (symbol == 8'h3d);
        cls.crc_check = crc_check;
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign deq_valid = (cnt_reg != 2'd0);
    assign deq_item  = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = deq_valid && deq_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### src/sbdc_back.sv
// Decode side: quartet assembly, byte emission, CRC32c and result register.
module sbdc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             deq_valid,
    output logic             deq_ready,
    input  sbdc_pkg::item_t  deq_item,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [13:0]      cfg_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       byte0,
    output logic [7:0]       byte1,
    output logic [7:0]       byte2,
    output logic [1:0]       byte_count,
    output logic             done_res,
    output logic [2:0]       status,
    output logic [13:0]      decoded_total
);

    logic [13:0]       cap_reg;
    logic [13:0]       cap_next;
    logic [17:0]       buf_reg;
    logic [17:0]       buf_next;
    logic              cpad_reg;
    logic              cpad_next;
    logic [1:0]        pos_reg;
    logic [1:0]        pos_next;
    logic              pseen_reg;
    logic              pseen_next;
    logic [13:0]       total_reg;
    logic [13:0]       total_next;
    logic [31:0]       crc_reg;
    logic [31:0]       crc_next;
    sbdc_pkg::status_t err_reg;
    sbdc_pkg::status_t err_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        b0_reg;
    logic [7:0]        b0_next;
    logic [7:0]        b1_reg;
    logic [7:0]        b1_next;
    logic [7:0]        b2_reg;
    logic [7:0]        b2_next;
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    logic              done_reg;
    logic              done_next;
    sbdc_pkg::status_t st_reg;
    sbdc_pkg::status_t st_next;
    logic [13:0]       tot_out_reg;
    logic [13:0]       tot_out_next;

    logic              fire;
    logic [5:0]        sa;
    logic [5:0]        sb;
    logic [5:0]        sc;
    logic [7:0]        v0;
    logic [7:0]        v1;
    logic [7:0]        v2;
    logic              d_pad;
    logic              q_bad;
    logic [1:0]        want;
    logic [1:0]        n;
    logic              f0;
    logic              f1;
    logic              f2;
    logic [31:0]       crc1;
    logic [31:0]       crc2;
    logic [31:0]       crc3;

    assign cfg_ready = 1'b1;
    assign deq_ready = !out_valid_reg || out_ready;
    assign fire      = deq_valid && deq_ready;

    always_comb
    begin
        sa    = buf_reg[17:12];
        sb    = buf_reg[11:6];
        sc    = buf_reg[5:0];
        d_pad = deq_item.is_pad;
        v0    = {sa, sb[5:4]};
        v1    = {sb[3:0], sc[5:2]};
        v2    = {sc[1:0], deq_item.sextet};
        q_bad = (!d_pad && deq_item.bad) || (cpad_reg && !d_pad) ||
                (cpad_reg && (sb[3:0] != 4'd0)) ||
                (d_pad && !cpad_reg && (sc[1:0] != 2'd0));
        want  = cpad_reg ? 2'd1 : (d_pad ? 2'd2 : 2'd3);
        f0    = ({1'b0, total_reg} < {1'b0, cap_reg});
        f1    = ({1'b0, total_reg} + 15'd1 < {1'b0, cap_reg});
        f2    = ({1'b0, total_reg} + 15'd2 < {1'b0, cap_reg});
        if (!f0)
        begin
            n = 2'd0;
        end
        else if (want == 2'd1 || !f1)
        begin
            n = 2'd1;
        end
        else if (want == 2'd2 || !f2)
        begin
            n = 2'd2;
        end
        else
        begin
            n = 2'd3;
        end
        crc1 = sbdc_pkg::crc_fold(crc_reg, v0);
        crc2 = sbdc_pkg::crc_fold(crc1, v1);
        crc3 = sbdc_pkg::crc_fold(crc2, v2);
    end

    always_comb
    begin
        cap_next       = (cfg_valid && cfg_ready) ? cfg_data : cap_reg;
        buf_next       = buf_reg;
        cpad_next      = cpad_reg;
        pos_next       = pos_reg;
        pseen_next     = pseen_reg;
        total_next     = total_reg;
        crc_next       = crc_reg;
        err_next       = err_reg;
        b0_next        = b0_reg;
        b1_next        = b1_reg;
        b2_next        = b2_reg;
        cnt_next       = cnt_reg;
        done_next      = done_reg;
        st_next        = st_reg;
        tot_out_next   = tot_out_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        if (fire)
        begin
            out_valid_next = 1'b1;
            b0_next        = 8'd0;
            b1_next        = 8'd0;
            b2_next        = 8'd0;
            cnt_next       = 2'd0;
            if (deq_item.is_end)
            begin
                if (pos_reg != 2'd0)
                begin
                    st_next = sbdc_pkg::ST_MALFORMED;
                end
                else if (err_reg != sbdc_pkg::ST_OK)
                begin
                    st_next = err_reg;
                end
                else if ({18'd0, total_reg} > 32'(sbdc_pkg::MAX_CHUNK_BYTES))
                begin
                    st_next = sbdc_pkg::ST_TOOBIG;
                end
                else if (~crc_reg != deq_item.crc_check)
                begin
                    st_next = sbdc_pkg::ST_CRC;
                end
                else
                begin
                    st_next = sbdc_pkg::ST_OK;
                end
                done_next    = 1'b1;
                tot_out_next = total_reg;
                buf_next     = 18'd0;
                cpad_next    = 1'b0;
                pos_next     = 2'd0;
                pseen_next   = 1'b0;
                total_next   = 14'd0;
                crc_next     = sbdc_pkg::CRC_INIT;
                err_next     = sbdc_pkg::ST_OK;
            end
            else
            begin
                if (pseen_reg)
                begin
                    err_next = sbdc_pkg::ST_MALFORMED;
                end
                else if (err_reg == sbdc_pkg::ST_OK)
                begin
                    case (pos_reg)
                        2'd0, 2'd1:
                        begin
                            if (deq_item.bad)
                            begin
                                err_next = sbdc_pkg::ST_MALFORMED;
                            end
                            else
                            begin
                                buf_next = {buf_reg[11:0], deq_item.sextet};
                            end
                            if (pos_reg == 2'd0)
                            begin
                                cpad_next = 1'b0;
                            end
                        end
                        2'd2:
                        begin
                            if (d_pad)
                            begin
                                cpad_next = 1'b1;
                                buf_next  = {buf_reg[11:0], 6'd0};
                            end
                            else if (deq_item.bad)
                            begin
                                err_next = sbdc_pkg::ST_MALFORMED;
                            end
                            else
                            begin
                                cpad_next = 1'b0;
                                buf_next  = {buf_reg[11:0], deq_item.sextet};
                            end
                        end
                        default:
                        begin
                            buf_next  = 18'd0;
                            cpad_next = 1'b0;
                            if (q_bad)
                            begin
                                err_next = sbdc_pkg::ST_MALFORMED;
                            end
                            else
                            begin
                                if (cpad_reg || d_pad)
                                begin
                                    pseen_next = 1'b1;
                                end
                                if (n != want)
                                begin
                                    err_next = sbdc_pkg::ST_NOSPACE;
                                end
                                cnt_next   = n;
                                total_next = total_reg + {12'd0, n};
                                b0_next    = (n >= 2'd1) ? v0 : 8'd0;
                                b1_next    = (n >= 2'd2) ? v1 : 8'd0;
                                b2_next    = (n == 2'd3) ? v2 : 8'd0;
                                case (n)
                                    2'd1:    crc_next = crc1;
                                    2'd2:    crc_next = crc2;
                                    2'd3:    crc_next = crc3;
                                    default: crc_next = crc_reg;
                                endcase
                            end
                        end
                    endcase
                end
                pos_next     = pos_reg + 2'd1;
                done_next    = 1'b0;
                st_next      = err_next;
                tot_out_next = total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        b0_reg      <= b0_next;
        b1_reg      <= b1_next;
        b2_reg      <= b2_next;
        cnt_reg     <= cnt_next;
        done_reg    <= done_next;
        st_reg      <= st_next;
        tot_out_reg <= tot_out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= sbdc_pkg::CAP_RESET;
            buf_reg       <= 18'd0;
            cpad_reg      <= 1'b0;
            pos_reg       <= 2'd0;
            pseen_reg     <= 1'b0;
            total_reg     <= 14'd0;
            crc_reg       <= sbdc_pkg::CRC_INIT;
            err_reg       <= sbdc_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            buf_reg       <= buf_next;
            cpad_reg      <= cpad_next;
            pos_reg       <= pos_next;
            pseen_reg     <= pseen_next;
            total_reg     <= total_next;
            crc_reg       <= crc_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign byte0         = b0_reg;
    assign byte1         = b1_reg;
    assign byte2         = b2_reg;
    assign byte_count    = cnt_reg;
    assign done_res      = done_reg;
    assign status        = st_reg;
    assign decoded_total = tot_out_reg;

`ifndef NO_ASSERTIONS
    a_done_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> cnt_reg == 2'd0)
        else $error("end result carries bytes");

    a_bytes_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && cnt_reg != 2'd0 |->
            st_reg == sbdc_pkg::ST_OK || st_reg == sbdc_pkg::ST_NOSPACE)
        else $error("bytes emitted under an error status");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && deq_item.is_end |=>
            pos_reg == 2'd0 && crc_reg == sbdc_pkg::CRC_INIT && total_reg == 14'd0)
        else $error("payload state not cleared after end item");
`endif

endmodule

### src/strict_base64_decode_crc32c_check_core.sv
// Top level of the strict base64 decoder with CRC32c check.
//
// Input channel (in_valid/in_ready): kind 0 carries one base64 character in
// symbol; kind 1 closes the payload and carries crc_check.
// Output channel (out_valid/out_ready): exactly one result per input item,
// holding up to three decoded bytes, byte_count, done_res, status and the
// running decoded_total.
// Config channel (cfg_valid/cfg_ready/cfg_data): sets the destination
// capacity in bytes; always ready. Write it only between payload items.
// With an idle receiver an input is written into the queue register and
// then decoded into the result register, where out_valid is raised.
// Throughput: one item per cycle unless the receiver stalls; the whole
// quartet and its three CRC byte folds finish in one decode-stage pass.
// A two-entry queue sits between the classifier and the decode stage, and
// the result register is refilled in the cycle it is taken, so a stalled
// receiver backs up into the queue and then drops in_ready.
// Reset: capacity returns to 4096, the payload state is cleared, the CRC
// returns to its initial value, and no result is pending.
module strict_base64_decode_crc32c_check_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  symbol,
    input  logic [31:0] crc_check,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [13:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  byte0,
    output logic [7:0]  byte1,
    output logic [7:0]  byte2,
    output logic [1:0]  byte_count,
    output logic        done_res,
    output logic [2:0]  status,
    output logic [13:0] decoded_total
);

    logic            deq_valid;
    logic            deq_ready;
    sbdc_pkg::item_t deq_item;

    sbdc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .symbol       (symbol),
        .crc_check    (crc_check),
        .deq_valid    (deq_valid),
        .deq_ready    (deq_ready),
        .deq_item     (deq_item)
    );

    sbdc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .deq_valid     (deq_valid),
        .deq_ready     (deq_ready),
        .deq_item      (deq_item),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .byte0         (byte0),
        .byte1         (byte1),
        .byte2         (byte2),
        .byte_count    (byte_count),
        .done_res      (done_res),
        .status        (status),
        .decoded_total (decoded_total)
    );

endmodule

### verif/tb_strict_base64_decode_crc32c_check_core.sv
// Testbench for the strict base64 decoder with CRC32c check, against a scoreboard.
`timescale 1ns / 1ps

module tb_strict_base64_decode_crc32c_check_core;

    localparam int HOLD_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic [2:0][7:0]   bytes;
        logic [1:0]        count;
        logic              done;
        sbdc_pkg::status_t status;
        logic [13:0]       total;
    } decode_result_t;

    typedef enum int {
        PL_CLEAN,
        PL_BAD_CRC,
        PL_BAD_CHAR,
        PL_EARLY_PAD,
        PL_LOOSE_BITS,
        PL_TRAILING,
        PL_SHORT,
        PL_PAD_MISMATCH
    } payload_flavor_t;

    // reflected CRC32c, one data bit at a time
    function automatic logic [31:0] crc32c_step(logic [31:0] c, logic [7:0] data);
        logic [31:0] x;
        x = c;
        for (int i = 0; i < 8; i++)
        begin
            if (x[0] ^ data[i])
            begin
                x = (x >> 1) ^ sbdc_pkg::CRC_POLY;
            end
            else
            begin
                x = x >> 1;
            end
        end
        return x;
    endfunction

    // 0..63 for alphabet characters, bit 6 set otherwise
    function automatic logic [6:0] alphabet_value(logic [7:0] ch);
        if (ch == "+")
        begin
            return 7'd62;
        end
        if (ch == "/")
        begin
            return 7'd63;
        end
        if (ch >= "0" && ch <= "9")
        begin
            return 7'(ch + 8'd4);
        end
        if (ch >= "a" && ch <= "z")
        begin
            return 7'(ch - 8'd71);
        end
        if (ch >= "A" && ch <= "Z")
        begin
            return 7'(ch - 8'd65);
        end
        return 7'h40;
    endfunction

    function automatic logic [7:0] b64_char(logic [5:0] v);
        if (v < 26)
        begin
            return 8'("A" + v);
        end
        if (v < 52)
        begin
            return 8'("a" + v - 26);
        end
        if (v < 62)
        begin
            return 8'("0" + v - 52);
        end
        return (v == 62) ? "+" : "/";
    endfunction

    class b64_crc_scoreboard;
        logic [13:0]       cap_bytes;
        logic [17:0]       sextet_acc;
        logic              third_pad;
        logic [1:0]        slot;
        logic              padded_done;
        logic [13:0]       byte_total;
        logic [31:0]       crc_acc;
        sbdc_pkg::status_t err;
        decode_result_t    awaited_results[$];
        int                mismatches;
        int                results_checked;
        int                items_taken;
        int                verdicts[5];

        function new();
            cap_bytes = sbdc_pkg::CAP_RESET;
            restart();
        endfunction

        function void restart();
            sextet_acc = '0;
            third_pad = 1'b0;
            slot = '0;
            padded_done = 1'b0;
            byte_total = '0;
            crc_acc = sbdc_pkg::CRC_INIT;
            err = sbdc_pkg::ST_OK;
        endfunction

        function void take_item(logic k, logic [7:0] ch, logic [31:0] check_crc);
            decode_result_t r;
            logic [6:0]     v;
            logic           is_pad;
            logic [5:0]     a, b, c;
            logic [7:0]     vals[3];
            int             want, n;
            r = '0;
            items_taken++;
            if (k)
            begin
                if (slot != 0)
                    r.status = sbdc_pkg::ST_MALFORMED;
                else if (err != sbdc_pkg::ST_OK)
                    r.status = err;
                else if (byte_total > sbdc_pkg::MAX_CHUNK_BYTES)
                    r.status = sbdc_pkg::ST_TOOBIG;
                else if (~crc_acc != check_crc)
                    r.status = sbdc_pkg::ST_CRC;
                else
                    r.status = sbdc_pkg::ST_OK;
                r.done = 1'b1;
                r.total = byte_total;
                verdicts[r.status]++;
                restart();
            end
            else
            begin
                v = alphabet_value(ch);
                is_pad = (ch == "=");
                if (padded_done)
                begin
                    err = sbdc_pkg::ST_MALFORMED;
                end
                else if (err == sbdc_pkg::ST_OK)
                begin
                    case (slot)
                        2'd0, 2'd1:
                        begin
                            if (v[6])
                                err = sbdc_pkg::ST_MALFORMED;
                            else
                                sextet_acc = {sextet_acc[11:0], v[5:0]};
                            if (slot == 2'd0)
                                third_pad = 1'b0;
                        end
                        2'd2:
                        begin
                            if (is_pad)
                            begin
                                third_pad = 1'b1;
                                sextet_acc = {sextet_acc[11:0], 6'd0};
                            end
                            else if (v[6])
                            begin
                                err = sbdc_pkg::ST_MALFORMED;
                            end
                            else
                            begin
                                third_pad = 1'b0;
                                sextet_acc = {sextet_acc[11:0], v[5:0]};
                            end
                        end
                        default:
                        begin
                            a = sextet_acc[17:12];
                            b = sextet_acc[11:6];
                            c = sextet_acc[5:0];
                            if ((!is_pad && v[6]) || (third_pad && !is_pad) ||
                                (third_pad && b[3:0] != 0) ||
                                (is_pad && !third_pad && c[1:0] != 0))
                            begin
                                err = sbdc_pkg::ST_MALFORMED;
                            end
                            else
                            begin
                                vals[0] = {a, b[5:4]};
                                vals[1] = {b[3:0], c[5:2]};
                                vals[2] = {c[1:0], v[5:0]};
                                want = third_pad ? 1 : (is_pad ? 2 : 3);
                                if (third_pad || is_pad)
                                    padded_done = 1'b1;
                                n = 0;
                                while (n < want && err == sbdc_pkg::ST_OK)
                                begin
                                    if (byte_total >= cap_bytes)
                                    begin
                                        err = sbdc_pkg::ST_NOSPACE;
                                    end
                                    else
                                    begin
                                        r.bytes[n] = vals[n];
                                        crc_acc = crc32c_step(crc_acc, vals[n]);
                                        byte_total = byte_total + 14'd1;
                                        n++;
                                    end
                                end
                                r.count = 2'(n);
                            end
                            sextet_acc = '0;
                            third_pad = 1'b0;
                        end
                    endcase
                end
                slot = slot + 2'd1;
                r.status = err;
                r.total = byte_total;
            end
            awaited_results.push_back(r);
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task compare_field(string name, int got, int want);
            if (got != want)
                report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                 results_checked, name, got, want));
        endtask

        task check_result(decode_result_t got);
            decode_result_t exp;
            if (awaited_results.size() == 0)
            begin
                report($sformatf("result with nothing pending (done %0b status %0d total %0d)",
                                 got.done, got.status, got.total));
                return;
            end
            exp = awaited_results.pop_front();
            compare_field("byte0", got.bytes[0], exp.bytes[0]);
            compare_field("byte1", got.bytes[1], exp.bytes[1]);
            compare_field("byte2", got.bytes[2], exp.bytes[2]);
            compare_field("byte_count", got.count, exp.count);
            compare_field("done_res", got.done, exp.done);
            compare_field("status", got.status, exp.status);
            compare_field("decoded_total", got.total, exp.total);
            results_checked++;
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        kind = 1'b0;
    logic [7:0]  symbol = 8'h00;
    logic [31:0] crc_check = 32'h0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [13:0] cfg_data = 14'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [1:0]  byte_count;
    logic        done_res;
    logic [2:0]  status;
    logic [13:0] decoded_total;

    b64_crc_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int items_offered = 0;
    int cfg_writes = 0;

    strict_base64_decode_crc32c_check_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .symbol        (symbol),
        .crc_check     (crc_check),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .byte0         (byte0),
        .byte1         (byte1),
        .byte2         (byte2),
        .byte_count    (byte_count),
        .done_res      (done_res),
        .status        (status),
        .decoded_total (decoded_total)
    );

    always #5 clk = ~clk;

    // receiver: random stalls, plus a long hold on request
    always @(posedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            holds_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // sampled mid-cycle; every transfer seen here completes at the next rising edge
    always @(negedge clk)
    begin
        decode_result_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.take_item(kind, symbol, crc_check);
            if (out_valid && out_ready)
            begin
                got.bytes[0] = byte0;
                got.bytes[1] = byte1;
                got.bytes[2] = byte2;
                got.count = byte_count;
                got.done = done_res;
                got.status = sbdc_pkg::status_t'(status);
                got.total = decoded_total;
                sb.check_result(got);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("strict_base64_decode_crc32c_check_core test failed");
                $finish;
            end
        end
    end

    task automatic push_item(input logic k, input logic [7:0] ch, input logic [31:0] crc_val);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            kind <= 1'($urandom);
            symbol <= 8'($urandom);
            crc_check <= $urandom;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        symbol <= ch;
        crc_check <= crc_val;
        items_offered++;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic send_symbol(input logic [7:0] ch);
        push_item(1'b0, ch, $urandom);
    endtask

    task automatic send_end(input logic [31:0] crc_val);
        push_item(1'b1, 8'($urandom), crc_val);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_symbol(s[i]);
    endtask

    // stop offering and wait until every pending result has been taken
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [13:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        sb.cap_bytes = v;
        cfg_writes++;
    endtask

    // encode random bytes, optionally break the text or the CRC, then close the payload
    task automatic send_payload(input int nbytes, input payload_flavor_t flavor);
        logic [7:0]  data[$];
        logic [7:0]  text[$];
        logic [31:0] crc;
        logic [7:0]  b0, b1, b2;
        logic [5:0]  s1, s2;
        int          rem, pos;
        if ((flavor == PL_LOOSE_BITS || flavor == PL_TRAILING) && nbytes % 3 == 0)
            nbytes++;
        if (flavor == PL_PAD_MISMATCH)
            nbytes = nbytes - nbytes % 3 + 1;
        crc = sbdc_pkg::CRC_INIT;
        for (int i = 0; i < nbytes; i++)
        begin
            data.push_back(8'($urandom));
            crc = crc32c_step(crc, data[i]);
        end
        for (int i = 0; i < nbytes; i += 3)
        begin
            rem = nbytes - i;
            b0 = data[i];
            b1 = (rem > 1) ? data[i + 1] : 8'h00;
            b2 = (rem > 2) ? data[i + 2] : 8'h00;
            s1 = {b0[1:0], b1[7:4]};
            s2 = {b1[3:0], b2[7:6]};
            if (flavor == PL_LOOSE_BITS && rem == 1)
                s1[3:0] = 4'($urandom_range(15, 1));
            if (flavor == PL_LOOSE_BITS && rem == 2)
                s2[1:0] = 2'($urandom_range(3, 1));
            text.push_back(b64_char(b0[7:2]));
            text.push_back(b64_char(s1));
            text.push_back((rem > 1) ? b64_char(s2) : "=");
            text.push_back((rem > 2) ? b64_char(b2[5:0]) : "=");
        end
        pos = (text.size() > 0) ? $urandom_range(text.size() - 1, 0) : 0;
        case (flavor)
            PL_BAD_CRC:
                crc ^= 32'h1 << $urandom_range(31, 0);
            PL_BAD_CHAR:
                if (text.size() > 0)
                    text[pos] = 8'($urandom);
                else
                    text.push_back(8'($urandom));
            PL_EARLY_PAD:
                if (text.size() > 0)
                    text[pos - pos % 4 + $urandom_range(1, 0)] = "=";
                else
                    text.push_back("=");
            PL_TRAILING:
                repeat ($urandom_range(4, 1)) text.push_back(b64_char(6'($urandom)));
            PL_SHORT:
                if (text.size() > 0 && $urandom_range(1, 0))
                    void'(text.pop_back());
                else
                    text.push_back(b64_char(6'($urandom)));
            PL_PAD_MISMATCH:
                text[text.size() - 1] = b64_char(6'($urandom));
            default:
                ;
        endcase
        foreach (text[i])
            send_symbol(text[i]);
        send_end(~crc);
    endtask

    task automatic run_random_phase(input int target, input int s_pct, input int r_pct,
                                    input logic [13:0] start_cap);
        int              first, iter, pick, nbytes;
        logic [13:0]     cap;
        payload_flavor_t flavor;
        write_capacity(start_cap);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        first = items_offered;
        iter = 0;
        while (items_offered - first < target)
        begin
            if (iter == 3)
            begin
                // long receiver stall while a full payload keeps coming
                hold_requests++;
                send_payload(12, PL_CLEAN);
            end
            if (iter > 0 && $urandom_range(7, 0) == 0)
            begin
                if ($urandom_range(1, 0))
                begin
                    case ($urandom_range(3, 0))
                        0: cap = 14'd0;
                        1: cap = 14'd8192;
                        2: cap = 14'($urandom_range(30, 1));
                        default: cap = 14'($urandom_range(8192, 0));
                    endcase
                    write_capacity(cap);
                end
                else
                begin
                    settle();
                end
            end
            pick = $urandom_range(99, 0);
            if (pick < 12)
            begin
                repeat ($urandom_range(8, 0))
                begin
                    case ($urandom_range(3, 0))
                        0: send_symbol("=");
                        1: send_symbol(b64_char(6'($urandom)));
                        default: send_symbol(8'($urandom));
                    endcase
                end
                send_end($urandom);
            end
            else
            begin
                nbytes = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 13)
                                                     : $urandom_range(12, 0);
                if (pick < 56)
                    flavor = PL_CLEAN;
                else
                    flavor = payload_flavor_t'($urandom_range(PL_PAD_MISMATCH, PL_BAD_CRC));
                send_payload(nbytes, flavor);
            end
            iter++;
        end
        settle();
    endtask

    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme sextets with a good CRC, loose pad bits, pad then data,
        // and a full destination overtaken by a symbol after padding
        send_text("////AAAA");
        send_end(~sb.crc_acc);
        send_text("TR==");
        send_end($urandom);
        send_text("TQ=A");
        send_end($urandom);
        write_capacity(14'd0);
        send_text("TQ==A");
        send_end($urandom);

        run_random_phase(135, 30, 68, 14'd24);
        run_random_phase(135, 68, 30, 14'd8192);
        run_random_phase(135, 0, 0, 14'($urandom_range(8192, 0)));
        settle();

        $display("Covered %0d items over %0d payloads, %0d capacity writes, %0d results checked",
                 sb.items_taken,
                 sb.verdicts[sbdc_pkg::ST_OK] + sb.verdicts[sbdc_pkg::ST_MALFORMED] +
                 sb.verdicts[sbdc_pkg::ST_NOSPACE] + sb.verdicts[sbdc_pkg::ST_TOOBIG] +
                 sb.verdicts[sbdc_pkg::ST_CRC],
                 cfg_writes, sb.results_checked);
        $display("Verdicts: ok %0d, malformed %0d, no space %0d, too big %0d, crc mismatch %0d",
                 sb.verdicts[sbdc_pkg::ST_OK], sb.verdicts[sbdc_pkg::ST_MALFORMED],
                 sb.verdicts[sbdc_pkg::ST_NOSPACE], sb.verdicts[sbdc_pkg::ST_TOOBIG],
                 sb.verdicts[sbdc_pkg::ST_CRC]);
        if (sb.mismatches == 0)
        begin
            $display("strict_base64_decode_crc32c_check_core test passed");
        end
        else
        begin
            $display("strict_base64_decode_crc32c_check_core test failed");
        end
        $finish;
    end

endmodule
